// ===== hw/rtl/mpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Media presentation clock package
// Event codes and fixed widths shared by the media clock modules.
// ----------------------------------------------------------------------------
package mpc_pkg;

    localparam int KIND_WIDTH = 3;
    localparam int RATE_WIDTH = 24;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_READ     = 3'd0,
        KIND_START    = 3'd1,
        KIND_SET_RATE = 3'd2,
        KIND_PAUSE    = 3'd3,
        KIND_RESUME   = 3'd4,
        KIND_SEEK     = 3'd5,
        KIND_SYNC     = 3'd6
    } t_kind;

    typedef struct packed {
        logic paused;
        logic applied;
    } t_evt_flags;

endpackage

// ===== hw/rtl/mpc_event_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Media clock event channel
// Valid/ready channel that carries one clock event per transaction.
// ----------------------------------------------------------------------------
interface mpc_event_if
    import mpc_pkg::*;
#(
    parameter int TIME_BITS = 48
);
    logic                          valid;
    logic                          ready;
    logic [KIND_WIDTH-1:0]         kind;
    logic [TIME_BITS-1:0]          wall_time;
    logic signed [TIME_BITS-1:0]   media_value;
    logic [RATE_WIDTH-1:0]         new_rate;

    modport source (output valid, kind, wall_time, media_value, new_rate, input ready);
    modport sink   (input valid, kind, wall_time, media_value, new_rate, output ready);
endinterface

// ===== hw/rtl/mpc_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Media clock result channel
// Valid/ready channel that carries one clock reading per transaction.
// ----------------------------------------------------------------------------
interface mpc_result_if #(
    parameter int TIME_BITS = 48
);
    logic                          valid;
    logic                          ready;
    logic signed [TIME_BITS-1:0]   media_time;
    logic                          is_paused;
    logic                          applied;

    modport source (output valid, media_time, is_paused, applied, input ready);
    modport sink   (input valid, media_time, is_paused, applied, output ready);
endinterface

// ===== hw/rtl/media_presentation_clock.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Media presentation clock
// Anchored media clock: each event transaction returns the clock reading at
// its wall time. A result is visible once its event has passed the input register
// and then the result register; throughput is one event per cycle unless the sink stalls the result.
// Synchronous active-low reset: anchors zero, running, rate one, wall master.
// ----------------------------------------------------------------------------
module media_presentation_clock
    import mpc_pkg::*;
#(
    parameter int TIME_BITS      = 48,
    parameter int RATE_FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    mpc_event_if.sink           i_in,
    mpc_result_if.source        o_out
);
    localparam logic [RATE_WIDTH-1:0] RATE_ONE = RATE_WIDTH'(1) << RATE_FRAC_BITS;

    logic                        r_s1_valid;
    logic [KIND_WIDTH-1:0]       r_s1_kind;
    logic [TIME_BITS-1:0]        r_s1_wall;
    logic signed [TIME_BITS-1:0] r_s1_media;
    logic [RATE_WIDTH-1:0]       r_s1_rate;

    logic signed [TIME_BITS-1:0] r_anchor_media;
    logic [TIME_BITS-1:0]        r_anchor_wall;
    logic                        r_paused;
    logic [RATE_WIDTH-1:0]       r_rate;
    logic                        r_master;

    logic                        r_out_valid;
    logic signed [TIME_BITS-1:0] r_out_media;
    logic                        r_out_paused;
    logic                        r_out_applied;

    logic                        w_advance;
    logic signed [TIME_BITS-1:0] w_reading;
    logic signed [TIME_BITS-1:0] n_anchor_media;
    logic [TIME_BITS-1:0]        n_anchor_wall;
    logic [RATE_WIDTH-1:0]       n_rate;
    logic signed [TIME_BITS-1:0] n_out_media;
    t_evt_flags                  n_flags;

    assign w_advance  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || w_advance;

    mpc_reading #(
        .TIME_BITS      (TIME_BITS),
        .RATE_FRAC_BITS (RATE_FRAC_BITS)
    ) u_reading (
        .i_anchor_media (r_anchor_media),
        .i_anchor_wall  (r_anchor_wall),
        .i_paused       (r_paused),
        .i_rate         (r_rate),
        .i_wall         (r_s1_wall),
        .o_reading      (w_reading)
    );

    mpc_event #(
        .TIME_BITS      (TIME_BITS),
        .RATE_FRAC_BITS (RATE_FRAC_BITS)
    ) u_event (
        .i_kind         (r_s1_kind),
        .i_wall         (r_s1_wall),
        .i_media        (r_s1_media),
        .i_new_rate     (r_s1_rate),
        .i_master       (r_master),
        .i_anchor_media (r_anchor_media),
        .i_anchor_wall  (r_anchor_wall),
        .i_paused       (r_paused),
        .i_rate         (r_rate),
        .i_reading      (w_reading),
        .o_anchor_media (n_anchor_media),
        .o_anchor_wall  (n_anchor_wall),
        .o_rate         (n_rate),
        .o_media_time   (n_out_media),
        .o_flags        (n_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_kind  <= i_in.kind;
            r_s1_wall  <= i_in.wall_time;
            r_s1_media <= i_in.media_value;
            r_s1_rate  <= i_in.new_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master <= 1'b0;
        end else if (i_cfg_we) begin
            r_master <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor_media <= '0;
            r_anchor_wall  <= '0;
            r_paused       <= 1'b0;
            r_rate         <= RATE_ONE;
        end else if (w_advance) begin
            r_anchor_media <= n_anchor_media;
            r_anchor_wall  <= n_anchor_wall;
            r_paused       <= n_flags.paused;
            r_rate         <= n_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_media   <= n_out_media;
            r_out_paused  <= n_flags.paused;
            r_out_applied <= n_flags.applied;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.media_time = r_out_media;
    assign o_out.is_paused  = r_out_paused;
    assign o_out.applied    = r_out_applied;

`ifndef SYNTH
    a_start_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_s1_kind == KIND_START)) |=> (!r_paused && (r_rate == RATE_ONE)))
        else $error("start transaction did not restore running state at rate one");

    a_paused_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> (o_out.is_paused == r_paused))
        else $error("reported pause flag differs from clock state");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled while the result register is empty");

    a_rate_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> (r_rate != '0))
        else $error("stored playback rate became zero");
`endif
endmodule

// ===== hw/rtl/mpc_reading.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Media clock reading
// Scales the elapsed wall time by the playback rate and adds it to the anchor media
// time, saturating at the largest signed time; while paused, returns the anchor media time.
// ----------------------------------------------------------------------------
module mpc_reading
    import mpc_pkg::*;
#(
    parameter int TIME_BITS      = 48,
    parameter int RATE_FRAC_BITS = 16
) (
    input  logic signed [TIME_BITS-1:0] i_anchor_media,
    input  logic [TIME_BITS-1:0]        i_anchor_wall,
    input  logic                        i_paused,
    input  logic [RATE_WIDTH-1:0]       i_rate,
    input  logic [TIME_BITS-1:0]        i_wall,
    output logic signed [TIME_BITS-1:0] o_reading
);
    localparam int HALF_BITS = TIME_BITS / 2;
    localparam int HIGH_BITS = TIME_BITS - HALF_BITS;
    localparam int PROD_BITS = TIME_BITS + RATE_WIDTH;
    localparam logic [RATE_WIDTH-1:0] RATE_ONE = RATE_WIDTH'(1) << RATE_FRAC_BITS;
    localparam logic signed [TIME_BITS+1:0] SUM_MAX = {3'b000, {(TIME_BITS-1){1'b1}}};

    logic [TIME_BITS-1:0]               w_elapsed;
    logic [RATE_WIDTH-1:0]              w_rate;
    logic [HALF_BITS+RATE_WIDTH-1:0]    w_prod_lo;
    logic [HIGH_BITS+RATE_WIDTH-1:0]    w_prod_hi;
    logic [PROD_BITS-1:0]               w_prod;
    logic [TIME_BITS-1:0]               w_inc;
    logic signed [TIME_BITS+1:0]        w_sum;

    always_comb begin
        w_elapsed = (i_wall > i_anchor_wall) ? (i_wall - i_anchor_wall) : '0;
        w_rate    = (i_rate == '0) ? RATE_ONE : i_rate;
        w_prod_lo = (HALF_BITS+RATE_WIDTH)'(w_elapsed[HALF_BITS-1:0])
                  * (HALF_BITS+RATE_WIDTH)'(w_rate);
        w_prod_hi = (HIGH_BITS+RATE_WIDTH)'(w_elapsed[TIME_BITS-1:HALF_BITS])
                  * (HIGH_BITS+RATE_WIDTH)'(w_rate);
        w_prod    = (PROD_BITS'(w_prod_hi) << HALF_BITS) + PROD_BITS'(w_prod_lo);
        if (|w_prod[PROD_BITS-1:TIME_BITS+RATE_FRAC_BITS]) begin
            w_inc = '1;
        end else begin
            w_inc = w_prod[TIME_BITS+RATE_FRAC_BITS-1:RATE_FRAC_BITS];
        end
        w_sum = $signed({2'b00, w_inc}) + $signed({{2{i_anchor_media[TIME_BITS-1]}},
                                                   i_anchor_media});
        if (i_paused) begin
            o_reading = i_anchor_media;
        end else if (w_sum > SUM_MAX) begin
            o_reading = SUM_MAX[TIME_BITS-1:0];
        end else begin
            o_reading = w_sum[TIME_BITS-1:0];
        end
    end
endmodule

// ===== hw/rtl/mpc_event.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Media clock event decode
// Applies one event to the clock anchor and selects the reading returned.
// ----------------------------------------------------------------------------
module mpc_event
    import mpc_pkg::*;
#(
    parameter int TIME_BITS      = 48,
    parameter int RATE_FRAC_BITS = 16
) (
    input  logic [KIND_WIDTH-1:0]       i_kind,
    input  logic [TIME_BITS-1:0]        i_wall,
    input  logic signed [TIME_BITS-1:0] i_media,
    input  logic [RATE_WIDTH-1:0]       i_new_rate,
    input  logic                        i_master,
    input  logic signed [TIME_BITS-1:0] i_anchor_media,
    input  logic [TIME_BITS-1:0]        i_anchor_wall,
    input  logic                        i_paused,
    input  logic [RATE_WIDTH-1:0]       i_rate,
    input  logic signed [TIME_BITS-1:0] i_reading,
    output logic signed [TIME_BITS-1:0] o_anchor_media,
    output logic [TIME_BITS-1:0]        o_anchor_wall,
    output logic [RATE_WIDTH-1:0]       o_rate,
    output logic signed [TIME_BITS-1:0] o_media_time,
    output t_evt_flags                  o_flags
);
    localparam logic [RATE_WIDTH-1:0] RATE_ONE = RATE_WIDTH'(1) << RATE_FRAC_BITS;

    always_comb begin
        o_anchor_media  = i_anchor_media;
        o_anchor_wall   = i_anchor_wall;
        o_rate          = i_rate;
        o_media_time    = i_reading;
        o_flags.paused  = i_paused;
        o_flags.applied = 1'b0;
        case (t_kind'(i_kind))
            KIND_START: begin
                o_anchor_media  = i_media;
                o_anchor_wall   = i_wall;
                o_rate          = RATE_ONE;
                o_media_time    = i_media;
                o_flags.paused  = 1'b0;
                o_flags.applied = 1'b1;
            end
            KIND_SET_RATE: begin
                if (i_new_rate != '0) begin
                    o_anchor_media  = i_reading;
                    o_anchor_wall   = i_wall;
                    o_rate          = i_new_rate;
                    o_flags.applied = 1'b1;
                end
            end
            KIND_PAUSE: begin
                if (!i_paused) begin
                    o_anchor_media  = i_reading;
                    o_anchor_wall   = i_wall;
                    o_flags.paused  = 1'b1;
                    o_flags.applied = 1'b1;
                end
            end
            KIND_RESUME: begin
                if (i_paused) begin
                    o_anchor_wall   = i_wall;
                    o_flags.paused  = 1'b0;
                    o_flags.applied = 1'b1;
                end
            end
            KIND_SEEK: begin
                o_anchor_media  = i_media[TIME_BITS-1] ? '0 : i_media;
                o_anchor_wall   = i_wall;
                o_media_time    = i_media[TIME_BITS-1] ? '0 : i_media;
                o_flags.applied = 1'b1;
            end
            KIND_SYNC: begin
                if (i_master && !i_paused) begin
                    o_anchor_media  = i_media;
                    o_anchor_wall   = i_wall;
                    o_media_time    = i_media;
                    o_flags.applied = 1'b1;
                end
            end
            default: begin
                o_flags.applied = 1'b0;
            end
        endcase
    end
endmodule
